// ===== rtl/grc_pkg.sv =====
`default_nettype none

package grc_pkg;

    // Field widths fixed by the item format
    localparam int ROW_W      = 10;
    localparam int COL_W      = 5;
    localparam int NROW_CFG_W = 11;
    localparam int NCOL_W     = 6;
    localparam int MIN_W      = 3;
    localparam int DIR_W      = 3;
    localparam int CLASS_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // One lane per addressable column
    localparam int LANES = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIRECTIONS = 2'd2;

    // Configuration reset values
    localparam logic [NROW_CFG_W-1:0] ROWS_IN_USE_RST    = 11'd1001;
    localparam logic [NCOL_W-1:0]     COLS_IN_USE_RST    = 6'd30;
    localparam logic [MIN_W-1:0]      MIN_DIRECTIONS_RST = 3'd3;

    // Item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Cell classes
    localparam logic [CLASS_W-1:0] CLASS_EMPTY   = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_FITTED  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_SOON    = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_MISSING = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_MOD,
        ST_SCAN,
        ST_DRAIN,
        ST_HAND
    } state_t;

    // Finished item handed from the sequencer to the result stage
    typedef struct packed {
        logic               valid;
        logic               query;
        logic [CLASS_W-1:0] wr_class;
        logic               up;
        logic               down;
        logic               missing;
        logic [COL_W-1:0]   col;
        logic [LANES-1:0]   fitted_row;
    } req_t;

endpackage

`default_nettype wire

// ===== rtl/grc_ram.sv =====
`default_nettype none

module grc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/grc_seq.sv =====
`default_nettype none

module grc_seq #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                mode,
    input  wire logic [grc_pkg::ROW_W-1:0]           row,
    input  wire logic [grc_pkg::COL_W-1:0]           col,
    input  wire logic                                is_fitted,
    input  wire logic                                is_missing,
    input  wire logic [$clog2(MAX_ROWS+1)-1:0]       nrows,
    input  wire logic [$clog2(MAX_ROWS)-1:0]         nrows_last,
    input  wire logic [grc_pkg::NCOL_W-1:0]          ncols,
    input  wire logic                                out_ready,
    output grc_pkg::req_t                            req,
    output logic                                     ram_we,
    output logic      [$clog2(MAX_ROWS)-1:0]         ram_waddr,
    output logic      [2*MAX_COLS-1:0]               ram_wdata,
    output logic                                     ram_re,
    output logic      [$clog2(MAX_ROWS)-1:0]         ram_raddr,
    input  wire logic [2*MAX_COLS-1:0]               ram_rdata
);

    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int DATA_W = 2 * MAX_COLS;
    localparam int NR_W   = $clog2(MAX_ROWS + 1);
    localparam int CMP_W  = ((NR_W > grc_pkg::ROW_W) ? NR_W : grc_pkg::ROW_W) + 1;
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(MAX_ROWS - 1);

    grc_pkg::state_t state_reg, state_next;

    logic [grc_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [grc_pkg::COL_W-1:0]   col_reg, col_next;
    logic                        fit_reg, fit_next;
    logic                        miss_reg, miss_next;
    logic                        query_reg, query_next;
    logic [grc_pkg::CLASS_W-1:0] wr_class_reg, wr_class_next;
    logic [ROW_AW-1:0]           rd_idx_reg, rd_idx_next;
    logic [ROW_AW-1:0]           chk_idx_reg, chk_idx_next;
    logic                        chk_valid_reg, chk_valid_next;
    logic                        up_reg, up_next;
    logic                        down_reg, down_next;
    logic                        cell_miss_reg, cell_miss_next;
    logic [grc_pkg::LANES-1:0]   fitted_row_reg, fitted_row_next;

    logic                        accept;
    logic                        wr_in_range;
    logic                        q_in_area;
    logic                        process;
    logic                        chk_at_row;
    logic                        chk_above;
    logic                        chk_below;
    logic [DATA_W-1:0]           scan_word;
    logic [DATA_W-1:0]           keep_mask;
    logic [DATA_W-1:0]           mod_word;
    logic [grc_pkg::LANES-1:0]   fitted_vec;
    logic [grc_pkg::NCOL_W-1:0]  col_ext;
    logic [grc_pkg::NCOL_W-1:0]  shamt;

    // Pick the fitted mark of every column out of the row word
    for (genvar j = 0; j < grc_pkg::LANES; j++)
    begin : g_lane
        if (j < MAX_COLS)
        begin : g_used
            assign fitted_vec[j] = ram_rdata[2*j];
        end
        else
        begin : g_pad
            assign fitted_vec[j] = 1'b0;
        end
    end

    // Decode the offered transaction
    always_comb
    begin
        accept      = in_valid && (state_reg == grc_pkg::ST_IDLE);
        col_ext     = {1'b0, col};
        wr_in_range = (CMP_W'(row) < CMP_W'(MAX_ROWS))
                   && (col_ext < grc_pkg::NCOL_W'(MAX_COLS));
        q_in_area   = (CMP_W'(row) < CMP_W'(nrows)) && (col_ext < ncols);
    end

    // Row word views for the scan and the read-modify-write
    always_comb
    begin
        shamt      = {col_reg, 1'b0};
        scan_word  = ram_rdata >> shamt;
        keep_mask  = ~(DATA_W'(2'b11) << shamt);
        mod_word   = (ram_rdata & keep_mask) | (DATA_W'({miss_reg, fit_reg}) << shamt);
        chk_at_row = CMP_W'(chk_idx_reg) == CMP_W'(row_reg);
        chk_above  = CMP_W'(chk_idx_reg) <= CMP_W'(row_reg);
        chk_below  = CMP_W'(chk_idx_reg) >= CMP_W'(row_reg);
        process    = ((state_reg == grc_pkg::ST_SCAN) && chk_valid_reg)
                  || (state_reg == grc_pkg::ST_DRAIN);
    end

    // Next state and memory control
    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        fit_next        = fit_reg;
        miss_next       = miss_reg;
        query_next      = query_reg;
        wr_class_next   = wr_class_reg;
        rd_idx_next     = rd_idx_reg;
        chk_idx_next    = chk_idx_reg;
        chk_valid_next  = chk_valid_reg;
        up_next         = up_reg;
        down_next       = down_reg;
        cell_miss_next  = cell_miss_reg;
        fitted_row_next = fitted_row_reg;

        ram_we    = 1'b0;
        ram_waddr = ROW_AW'(row_reg);
        ram_wdata = mod_word;
        ram_re    = 1'b0;
        ram_raddr = ROW_AW'(row);

        case (state_reg)
            grc_pkg::ST_CLEAR:
            begin
                // Sweep zeros through the store, one row per cycle
                ram_we    = 1'b1;
                ram_waddr = rd_idx_reg;
                ram_wdata = '0;
                if (rd_idx_reg == LAST_ROW)
                begin
                    rd_idx_next = '0;
                    state_next  = grc_pkg::ST_IDLE;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + ROW_AW'(1);
                end
            end

            grc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    row_next        = row;
                    col_next        = col;
                    fit_next        = is_fitted;
                    miss_next       = is_missing;
                    query_next      = 1'b0;
                    wr_class_next   = grc_pkg::CLASS_EMPTY;
                    up_next         = 1'b0;
                    down_next       = 1'b0;
                    cell_miss_next  = 1'b0;
                    fitted_row_next = '0;
                    rd_idx_next     = '0;
                    chk_valid_next  = 1'b0;
                    state_next      = grc_pkg::ST_HAND;
                    if (mode == grc_pkg::MODE_WRITE)
                    begin
                        if (wr_in_range)
                        begin
                            ram_re     = 1'b1;
                            state_next = grc_pkg::ST_WR_MOD;
                        end
                    end
                    else if (q_in_area)
                    begin
                        query_next = 1'b1;
                        state_next = grc_pkg::ST_SCAN;
                    end
                end
            end

            grc_pkg::ST_WR_MOD:
            begin
                // Merge the new marks into the row and write it back
                ram_we = 1'b1;
                if (fit_reg)
                begin
                    wr_class_next = grc_pkg::CLASS_FITTED;
                end
                else if (miss_reg)
                begin
                    wr_class_next = grc_pkg::CLASS_MISSING;
                end
                else
                begin
                    wr_class_next = grc_pkg::CLASS_EMPTY;
                end
                state_next = grc_pkg::ST_HAND;
            end

            grc_pkg::ST_SCAN:
            begin
                // Issue one row read per cycle down the area in use
                ram_re         = 1'b1;
                ram_raddr      = rd_idx_reg;
                chk_idx_next   = rd_idx_reg;
                chk_valid_next = 1'b1;
                rd_idx_next    = rd_idx_reg + ROW_AW'(1);
                if (rd_idx_reg == nrows_last)
                begin
                    state_next = grc_pkg::ST_DRAIN;
                end
            end

            grc_pkg::ST_DRAIN:
            begin
                state_next = grc_pkg::ST_HAND;
            end

            grc_pkg::ST_HAND:
            begin
                if (out_ready)
                begin
                    state_next = grc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = grc_pkg::ST_IDLE;
            end
        endcase

        // Fold the returned row into the column rays and capture the queried row
        if (process)
        begin
            if (scan_word[0] && chk_above)
            begin
                up_next = 1'b1;
            end
            if (scan_word[0] && chk_below)
            begin
                down_next = 1'b1;
            end
            if (chk_at_row)
            begin
                fitted_row_next = fitted_vec;
                cell_miss_next  = scan_word[1];
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= grc_pkg::ST_CLEAR;
            rd_idx_reg    <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    // Item and scan payload
    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        col_reg        <= col_next;
        fit_reg        <= fit_next;
        miss_reg       <= miss_next;
        query_reg      <= query_next;
        wr_class_reg   <= wr_class_next;
        chk_idx_reg    <= chk_idx_next;
        up_reg         <= up_next;
        down_reg       <= down_next;
        cell_miss_reg  <= cell_miss_next;
        fitted_row_reg <= fitted_row_next;
    end

    assign in_stall = (state_reg != grc_pkg::ST_IDLE);

    always_comb
    begin
        req.valid      = (state_reg == grc_pkg::ST_HAND);
        req.query      = query_reg;
        req.wr_class   = wr_class_reg;
        req.up         = up_reg;
        req.down       = down_reg;
        req.missing    = cell_miss_reg;
        req.col        = col_reg;
        req.fitted_row = fitted_row_reg;
    end

endmodule

`default_nettype wire

// ===== rtl/grc_out.sv =====
`default_nettype none

module grc_out (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire grc_pkg::req_t                     req,
    input  wire logic [grc_pkg::NCOL_W-1:0]        ncols,
    input  wire logic [grc_pkg::MIN_W-1:0]         min_dir,
    output logic                                   out_ready,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   to_be_fitted,
    output logic      [grc_pkg::DIR_W-1:0]         directions_found,
    output logic      [grc_pkg::CLASS_W-1:0]       cell_class
);

    logic                        out_valid_reg, out_valid_next;
    logic                        soon_reg, soon_next;
    logic [grc_pkg::DIR_W-1:0]   dir_reg, dir_next;
    logic [grc_pkg::CLASS_W-1:0] class_reg, class_next;

    logic [grc_pkg::LANES-1:0]   left_mask;
    logic [grc_pkg::LANES-1:0]   right_mask;
    logic                        left;
    logic                        right;
    logic                        self_fitted;
    logic [grc_pkg::DIR_W-1:0]   count;
    logic                        soon;
    logic                        load;

    // Row rays: columns up to the cell, and from the cell to the border
    always_comb
    begin
        for (int j = 0; j < grc_pkg::LANES; j++)
        begin
            left_mask[j]  = (grc_pkg::COL_W'(j) <= req.col);
            right_mask[j] = (grc_pkg::COL_W'(j) >= req.col)
                         && (grc_pkg::NCOL_W'(j) < ncols);
        end
        left        = |(req.fitted_row & left_mask);
        right       = |(req.fitted_row & right_mask);
        self_fitted = |(req.fitted_row & left_mask & right_mask);
        count       = {2'b00, req.up} + {2'b00, req.down}
                    + {2'b00, left} + {2'b00, right};
        soon        = req.missing && (count >= min_dir);
    end

    // Load a finished item into the output register
    always_comb
    begin
        out_ready      = !out_valid_reg || !out_stall;
        load           = req.valid && out_ready;
        out_valid_next = out_valid_reg;
        soon_next      = soon_reg;
        dir_next       = dir_reg;
        class_next     = class_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load)
        begin
            out_valid_next = 1'b1;
            if (req.query)
            begin
                soon_next = soon;
                dir_next  = count;
                if (self_fitted)
                begin
                    class_next = grc_pkg::CLASS_FITTED;
                end
                else if (soon)
                begin
                    class_next = grc_pkg::CLASS_SOON;
                end
                else if (req.missing)
                begin
                    class_next = grc_pkg::CLASS_MISSING;
                end
                else
                begin
                    class_next = grc_pkg::CLASS_EMPTY;
                end
            end
            else
            begin
                soon_next  = 1'b0;
                dir_next   = '0;
                class_next = req.wr_class;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        soon_reg  <= soon_next;
        dir_reg   <= dir_next;
        class_reg <= class_next;
    end

    assign out_valid        = out_valid_reg;
    assign to_be_fitted     = soon_reg;
    assign directions_found = dir_reg;
    assign cell_class       = class_reg;

endmodule

`default_nettype wire

// ===== rtl/grid_ray_enclosure_classifier.sv =====
`default_nettype none

// Grid classifier for missing cells. Each grid row lives in one word of a
// single-port-per-side memory (two mark bits per column). An in-range write
// transaction reads the row and writes it back with the new marks. A query
// transaction inside the area in use walks the queried column through the
// memory one row per cycle over every row in use (rows_in_use saturated to
// 1..MAX_ROWS). One transaction is worked on at a time; the next one is
// taken while the previous result waits in the output register. After reset
// the block clears every row of the grid and holds in_stall high meanwhile;
// configuration writes are taken at any time and should be issued only while
// no transaction is in flight.
module grid_ray_enclosure_classifier #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 32
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [grc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [grc_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 mode,
    input  wire logic [grc_pkg::ROW_W-1:0]            row,
    input  wire logic [grc_pkg::COL_W-1:0]            col,
    input  wire logic                                 is_fitted,
    input  wire logic                                 is_missing,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      to_be_fitted,
    output logic      [grc_pkg::DIR_W-1:0]            directions_found,
    output logic      [grc_pkg::CLASS_W-1:0]          cell_class
);

    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int DATA_W = 2 * MAX_COLS;
    localparam int NR_W   = $clog2(MAX_ROWS + 1);
    localparam int RW     = ((NR_W > grc_pkg::NROW_CFG_W) ? NR_W : grc_pkg::NROW_CFG_W) + 1;

    logic [grc_pkg::NROW_CFG_W-1:0] rows_in_use_reg;
    logic [grc_pkg::NCOL_W-1:0]     cols_in_use_reg;
    logic [grc_pkg::MIN_W-1:0]      min_directions_reg;

    logic [RW-1:0]                  rows_wide;
    logic [NR_W-1:0]                nrows;
    logic [ROW_AW-1:0]              nrows_last;
    logic [grc_pkg::NCOL_W-1:0]     ncols;

    grc_pkg::req_t                  req;
    logic                           out_ready;

    logic                           ram_we;
    logic [ROW_AW-1:0]              ram_waddr;
    logic [DATA_W-1:0]              ram_wdata;
    logic                           ram_re;
    logic [ROW_AW-1:0]              ram_raddr;
    logic [DATA_W-1:0]              ram_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg    <= grc_pkg::ROWS_IN_USE_RST;
            cols_in_use_reg    <= grc_pkg::COLS_IN_USE_RST;
            min_directions_reg <= grc_pkg::MIN_DIRECTIONS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                grc_pkg::REG_ROWS_IN_USE:
                begin
                    rows_in_use_reg <= cfg_data;
                end
                grc_pkg::REG_COLS_IN_USE:
                begin
                    cols_in_use_reg <= cfg_data[grc_pkg::NCOL_W-1:0];
                end
                grc_pkg::REG_MIN_DIRECTIONS:
                begin
                    min_directions_reg <= cfg_data[grc_pkg::MIN_W-1:0];
                end
                default:
                begin
                    rows_in_use_reg <= rows_in_use_reg;
                end
            endcase
        end
    end

    // Saturate the area in use to the grid store
    always_comb
    begin
        rows_wide = RW'(rows_in_use_reg);
        if (rows_wide == '0)
        begin
            nrows = NR_W'(1);
        end
        else if (rows_wide > RW'(MAX_ROWS))
        begin
            nrows = NR_W'(MAX_ROWS);
        end
        else
        begin
            nrows = NR_W'(rows_wide);
        end
        nrows_last = ROW_AW'(nrows - NR_W'(1));

        if (cols_in_use_reg == '0)
        begin
            ncols = grc_pkg::NCOL_W'(1);
        end
        else if (cols_in_use_reg > grc_pkg::NCOL_W'(MAX_COLS))
        begin
            ncols = grc_pkg::NCOL_W'(MAX_COLS);
        end
        else
        begin
            ncols = cols_in_use_reg;
        end
    end

    grc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    grc_seq #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .row        (row),
        .col        (col),
        .is_fitted  (is_fitted),
        .is_missing (is_missing),
        .nrows      (nrows),
        .nrows_last (nrows_last),
        .ncols      (ncols),
        .out_ready  (out_ready),
        .req        (req),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    grc_out u_out (
        .clk              (clk),
        .rst_n            (rst_n),
        .req              (req),
        .ncols            (ncols),
        .min_dir          (min_directions_reg),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .to_be_fitted     (to_be_fitted),
        .directions_found (directions_found),
        .cell_class       (cell_class)
    );

`ifndef SYNTHESIS
    // One transaction at a time: an accepted item closes the input
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while a transaction was in flight");

    // A to-be-fitted result meets the threshold; a fitted mark may still win the class
    a_soon_class: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && to_be_fitted) |->
            ((cell_class == grc_pkg::CLASS_SOON) || (cell_class == grc_pkg::CLASS_FITTED))
            && (directions_found >= min_directions_reg))
        else $error("to_be_fitted result inconsistent with class or count");

    // At most four directions can be found
    a_dir_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (directions_found <= 3'd4))
        else $error("direction count above four");
`endif

endmodule

`default_nettype wire

// ===== tb/grid_ray_enclosure_classifier_tb.sv =====
`timescale 1ns / 100ps

module grid_ray_enclosure_classifier_tb;
    import grc_pkg::*;

    localparam int GRID_ROWS = 1024;
    localparam int GRID_COLS = 32;

    // Index with no register behind it; writes there must have no effect
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic               tbf;
        logic [DIR_W-1:0]   dirs;
        logic [CLASS_W-1:0] cls;
    } verdict_t;

    // Shadow grid, shadow registers and the queue of classifications owed
    class enclosure_scoreboard;
        bit [GRID_COLS-1:0]    fit_map  [GRID_ROWS];
        bit [GRID_COLS-1:0]    miss_map [GRID_ROWS];
        bit [NROW_CFG_W-1:0]   rows_reg;
        bit [NCOL_W-1:0]       cols_reg;
        bit [MIN_W-1:0]        min_reg;
        verdict_t              owed [$];
        int                    mismatches;
        int                    failures;

        function new();
            for (int i = 0; i < GRID_ROWS; i++)
            begin
                fit_map[i]  = '0;
                miss_map[i] = '0;
            end
            rows_reg   = ROWS_IN_USE_RST;
            cols_reg   = COLS_IN_USE_RST;
            min_reg    = MIN_DIRECTIONS_RST;
            mismatches = 0;
            failures   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ROWS_IN_USE:    rows_reg = data[NROW_CFG_W-1:0];
                REG_COLS_IN_USE:    cols_reg = data[NCOL_W-1:0];
                REG_MIN_DIRECTIONS: min_reg  = data[MIN_W-1:0];
                default:            ;
            endcase
        endfunction

        // Work out the classification owed for one accepted transaction
        function void note_item(logic md, logic [ROW_W-1:0] r, logic [COL_W-1:0] c,
                                logic f, logic mi);
            verdict_t v;
            int       nrows;
            int       ncols;
            int       hits;
            bit       up;
            bit       down;
            bit       lft;
            bit       rgt;
            bit       soon;
            v = '0;
            if (md == MODE_WRITE)
            begin
                fit_map[r][c]  = f;
                miss_map[r][c] = mi;
                v.cls = f ? CLASS_FITTED : (mi ? CLASS_MISSING : CLASS_EMPTY);
            end
            else
            begin
                nrows = (rows_reg == 0) ? 1 : ((rows_reg > GRID_ROWS) ? GRID_ROWS : rows_reg);
                ncols = (cols_reg == 0) ? 1 : ((cols_reg > GRID_COLS) ? GRID_COLS : cols_reg);
                if (int'(r) < nrows && int'(c) < ncols)
                begin
                    up = 0;
                    down = 0;
                    lft = 0;
                    rgt = 0;
                    // Each ray includes the queried cell itself
                    for (int i = 0; i <= int'(r); i++)
                        up |= fit_map[i][c];
                    for (int i = int'(r); i < nrows; i++)
                        down |= fit_map[i][c];
                    for (int j = 0; j <= int'(c); j++)
                        lft |= fit_map[r][j];
                    for (int j = int'(c); j < ncols; j++)
                        rgt |= fit_map[r][j];
                    hits = int'(up) + int'(down) + int'(lft) + int'(rgt);
                    soon = miss_map[r][c] && (hits >= int'(min_reg));
                    v.tbf  = soon;
                    v.dirs = DIR_W'(hits);
                    if (fit_map[r][c])
                        v.cls = CLASS_FITTED;
                    else if (soon)
                        v.cls = CLASS_SOON;
                    else if (miss_map[r][c])
                        v.cls = CLASS_MISSING;
                    else
                        v.cls = CLASS_EMPTY;
                end
            end
            owed.push_back(v);
        endfunction

        // Compare one delivered classification with the oldest one owed
        function void check_result(logic tbf, logic [DIR_W-1:0] dirs, logic [CLASS_W-1:0] cls);
            verdict_t want;
            if (owed.size() == 0)
            begin
                mismatches++;
                failures++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result tbf=%0d dirs=%0d class=%0d",
                             $realtime, tbf, dirs, cls);
                return;
            end
            want = owed.pop_front();
            if (want.tbf !== tbf || want.dirs !== dirs || want.cls !== cls)
            begin
                mismatches++;
                failures++;
                if (mismatches <= 10)
                    $display("%0t: mismatch expected tbf=%0d dirs=%0d class=%0d, got tbf=%0d dirs=%0d class=%0d",
                             $realtime, want.tbf, want.dirs, want.cls, tbf, dirs, cls);
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  mode = MODE_WRITE;
    logic [ROW_W-1:0]      row = '0;
    logic [COL_W-1:0]      col = '0;
    logic                  is_fitted = 1'b0;
    logic                  is_missing = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  to_be_fitted;
    logic [DIR_W-1:0]      directions_found;
    logic [CLASS_W-1:0]    cell_class;

    bit                    idle_on = 1'b1;
    int                    hold_request = 0;

    enclosure_scoreboard   board = new();

    grid_ray_enclosure_classifier #(
        .MAX_ROWS (GRID_ROWS),
        .MAX_COLS (GRID_COLS)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .mode             (mode),
        .row              (row),
        .col              (col),
        .is_fitted        (is_fitted),
        .is_missing       (is_missing),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .to_be_fitted     (to_be_fitted),
        .directions_found (directions_found),
        .cell_class       (cell_class)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Check every result transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(to_be_fitted, directions_found, cell_class);
    end

    // Result side: random stalls per transaction while idle_on is set, plus a long hold on request
    initial
    begin : result_taker
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_request) @(posedge clk);
                hold_request = 0;
            end
            n = idle_on ? $urandom_range(0, 6) : 0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Offer one transaction and hold it until taken
    task automatic send_item(input logic md, input logic [ROW_W-1:0] r,
                             input logic [COL_W-1:0] c, input logic f, input logic mi);
        int gap;
        gap = idle_on ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= md;
        row        <= r;
        col        <= c;
        is_fitted  <= f;
        is_missing <= mi;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_item(md, r, c, f, mi);
    endtask

    // Drop valid after a burst
    task automatic end_burst();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait until every owed result has come back
    task automatic drain();
        while (board.pending() != 0) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        board.set_register(idx, data);
    endtask

    // One random phase: new settings, then a mix of writes and queries
    task automatic random_phase(input int k, input int n_items);
        logic [CFG_DATA_W-1:0] rows_data;
        int                    col_val;
        int                    min_val;
        int                    eff_rows;
        int                    eff_cols;
        logic                  md;
        logic                  f;
        logic                  mi;
        logic [ROW_W-1:0]      r;
        logic [COL_W-1:0]      c;
        if (k == 4)
            rows_data = ($urandom_range(0, 1) != 0) ? 11'd2047 : 11'd1024;
        else if (k == 2)
            rows_data = CFG_DATA_W'($urandom_range(0, 1));
        else
            rows_data = CFG_DATA_W'($urandom_range(2, 64));
        if (k == 1)
            col_val = 1;
        else if (k == 3)
            col_val = 63;
        else if (k == 6)
            col_val = 0;
        else
            col_val = $urandom_range(1, 32);
        min_val = (k < 8) ? k : $urandom_range(1, 4);
        eff_rows = (rows_data == 0) ? 1 : ((rows_data > GRID_ROWS) ? GRID_ROWS : rows_data);
        eff_cols = (col_val == 0) ? 1 : ((col_val > GRID_COLS) ? GRID_COLS : col_val);

        if (k == 0)
            write_register(REG_SPARE, CFG_DATA_W'($urandom));
        write_register(REG_ROWS_IN_USE, rows_data);
        write_register(REG_COLS_IN_USE, {5'($urandom), 6'(col_val)});
        write_register(REG_MIN_DIRECTIONS, {8'($urandom), 3'(min_val)});

        idle_on = (k % 3 != 2);
        if (k == 5)
            hold_request = 300;

        for (int i = 0; i < n_items; i++)
        begin
            // Pause the sender until the block has emptied
            if (i == n_items / 2)
            begin
                end_burst();
                drain();
            end
            md = ($urandom_range(0, 99) < 45) ? MODE_QUERY : MODE_WRITE;
            if ($urandom_range(0, 9) == 0)
            begin
                r = ROW_W'($urandom);
                c = COL_W'($urandom);
            end
            else
            begin
                r = ROW_W'($urandom_range(0, eff_rows - 1));
                c = COL_W'($urandom_range(0, eff_cols - 1));
            end
            f  = ($urandom_range(0, 3) == 0);
            mi = $urandom_range(0, 1);
            send_item(md, r, c, f, mi);
        end
        end_burst();
        drain();
    endtask

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: build a cross around cell (5,5)
        send_item(MODE_WRITE, 10'd5, 5'd5, 1'b0, 1'b1);
        send_item(MODE_WRITE, 10'd2, 5'd5, 1'b1, 1'b0);
        send_item(MODE_WRITE, 10'd9, 5'd5, 1'b1, 1'b0);
        send_item(MODE_WRITE, 10'd5, 5'd1, 1'b1, 1'b0);
        send_item(MODE_QUERY, 10'd5, 5'd5, 1'b0, 1'b0);
        send_item(MODE_WRITE, 10'd5, 5'd29, 1'b1, 1'b0);
        send_item(MODE_QUERY, 10'd5, 5'd5, 1'b1, 1'b1);
        // Fitted cell sees itself in all four rays
        send_item(MODE_QUERY, 10'd5, 5'd29, 1'b0, 1'b1);
        // Both marks: fitted wins
        send_item(MODE_WRITE, 10'd1023, 5'd31, 1'b1, 1'b1);
        send_item(MODE_WRITE, 10'd1000, 5'd29, 1'b0, 1'b1);
        send_item(MODE_QUERY, 10'd1000, 5'd29, 1'b1, 1'b0);
        // Queries outside the area in use
        send_item(MODE_QUERY, 10'd1001, 5'd0, 1'b0, 1'b0);
        send_item(MODE_QUERY, 10'd0, 5'd30, 1'b0, 1'b0);
        // Clear a neighbor and query again
        send_item(MODE_WRITE, 10'd5, 5'd1, 1'b0, 1'b0);
        send_item(MODE_QUERY, 10'd5, 5'd5, 1'b0, 1'b0);
        send_item(MODE_QUERY, 10'd0, 5'd0, 1'b0, 1'b0);
        end_burst();
        drain();

        // Zero sizes saturate to one cell; zero threshold is always met
        write_register(REG_ROWS_IN_USE, 11'd0);
        write_register(REG_COLS_IN_USE, 11'h7C0);
        write_register(REG_MIN_DIRECTIONS, 11'h7F8);
        send_item(MODE_WRITE, 10'd0, 5'd0, 1'b0, 1'b1);
        send_item(MODE_QUERY, 10'd0, 5'd0, 1'b0, 1'b0);
        send_item(MODE_QUERY, 10'd0, 5'd1, 1'b0, 1'b0);
        end_burst();
        drain();

        // Oversized values saturate to the full grid; threshold above four never met
        write_register(REG_SPARE, 11'h555);
        write_register(REG_ROWS_IN_USE, 11'd2047);
        write_register(REG_COLS_IN_USE, 11'd63);
        write_register(REG_MIN_DIRECTIONS, 11'd7);
        send_item(MODE_WRITE, 10'd1023, 5'd30, 1'b0, 1'b1);
        send_item(MODE_QUERY, 10'd1023, 5'd30, 1'b0, 1'b0);
        send_item(MODE_QUERY, 10'd1023, 5'd31, 1'b0, 1'b0);
        end_burst();
        drain();

        // Full grid, threshold four
        write_register(REG_ROWS_IN_USE, 11'd1024);
        write_register(REG_COLS_IN_USE, 11'd32);
        write_register(REG_MIN_DIRECTIONS, 11'd4);
        send_item(MODE_WRITE, 10'd5, 5'd0, 1'b1, 1'b0);
        send_item(MODE_QUERY, 10'd5, 5'd5, 1'b0, 1'b0);
        send_item(MODE_QUERY, 10'd1023, 5'd0, 1'b0, 1'b0);
        end_burst();
        drain();

        // Random phases; the full-height phase is kept short
        for (int k = 0; k < 10; k++)
            random_phase(k, (k == 4) ? 20 : 62);

        repeat (1100) @(posedge clk);
        if (board.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
